### rtl/pfw_pkg.sv
// types, register codes and constants shared by the framebuffer pixel writer
package pfw_pkg;

    localparam logic [2:0] REG_PIXEL_FORMAT      = 3'd0;
    localparam logic [2:0] REG_TRANSPARENCY_MODE = 3'd1;
    localparam logic [2:0] REG_BIG_ENDIAN        = 3'd2;
    localparam logic [2:0] REG_IMAGE_WIDTH       = 3'd3;
    localparam logic [2:0] REG_IMAGE_HEIGHT      = 3'd4;

    localparam logic [1:0] FMT_BINARY    = 2'd0;
    localparam logic [1:0] FMT_GRAYSCALE = 2'd1;
    localparam logic [1:0] FMT_RGB565    = 2'd2;
    localparam logic [1:0] FMT_RGB888    = 2'd3;

    localparam logic [1:0] MODE_OPAQUE = 2'd0;
    localparam logic [1:0] MODE_CHROMA = 2'd1;
    localparam logic [1:0] MODE_ALPHA  = 2'd2;

    localparam logic [14:0] MAX_DIM = 15'd32767;

    localparam logic [23:0] LUMA_R = 24'd13926;
    localparam logic [23:0] LUMA_G = 24'd46885;
    localparam logic [23:0] LUMA_B = 24'd4725;

    localparam logic [7:0] HALF_ALPHA = 8'h80;
    localparam logic [7:0] FULL_BYTE  = 8'hFF;

    typedef struct packed {
        logic [1:0]  pixel_format;
        logic [1:0]  transparency_mode;
        logic        big_endian;
        logic [14:0] image_width;
        logic [14:0] image_height;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  alpha;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        logic [15:0] pos_y;
        logic [15:0] pos_x;
    } pixel_t;

    typedef struct packed {
        logic        oor;
        logic [14:0] x;
        logic [30:0] prod;
        logic [29:0] wh;
        logic [23:0] lum_r;
        logic [23:0] lum_g;
        logic [23:0] lum_b;
        logic        bright;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [7:0]  a;
    } stage1_t;

    typedef struct packed {
        logic        oor;
        logic [30:0] idx;
        logic [29:0] wh;
        logic [7:0]  gray;
        logic        on;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [7:0]  a;
    } calc_t;

    typedef struct packed {
        logic [1:0]       last_idx;
        logic             oor;
        logic [7:0]       mask;
        logic [3:0][31:0] addr;
        logic [3:0][7:0]  data;
    } beat_set_t;

endpackage

### rtl/pfw_calc.sv
// first two pipeline stages: bounds check, multiplies, luma and color remap
module pfw_calc (
    input  logic            clk,
    input  logic            rst_n,
    input  pfw_pkg::cfg_t   cfg,
    input  logic            in_valid,
    output logic            in_ready,
    input  pfw_pkg::pixel_t in_pixel,
    output logic            out_valid,
    input  logic            out_ready,
    output pfw_pkg::calc_t  out_calc
);

    pfw_pkg::stage1_t s1_next;
    pfw_pkg::stage1_t s1_reg;
    logic             v1_reg;
    pfw_pkg::calc_t   s2_next;
    pfw_pkg::calc_t   s2_reg;
    logic             v2_reg;
    logic             en1;
    logic             en2;

    logic [15:0] w_round;
    logic [15:0] w_sel;
    logic        chroma;
    logic        alpha_ch;
    logic [23:0] lum_sum;

    assign en2      = !v2_reg || out_ready;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;
    assign chroma   = (cfg.transparency_mode == pfw_pkg::MODE_CHROMA);
    assign alpha_ch = (cfg.transparency_mode == pfw_pkg::MODE_ALPHA);

    always_comb
    begin
        w_round = {1'b0, cfg.image_width} + 16'd7;
        w_sel   = (cfg.pixel_format == pfw_pkg::FMT_BINARY) ? {w_round[15:3], 3'b000}
                                                             : {1'b0, cfg.image_width};
        s1_next.oor = in_pixel.pos_x[15] || in_pixel.pos_y[15]
                   || (cfg.image_width == 15'd0) || (cfg.image_height == 15'd0)
                   || (cfg.image_width > pfw_pkg::MAX_DIM)
                   || (cfg.image_height > pfw_pkg::MAX_DIM)
                   || (in_pixel.pos_x[14:0] >= cfg.image_width)
                   || (in_pixel.pos_y[14:0] >= cfg.image_height);
        s1_next.x      = in_pixel.pos_x[14:0];
        s1_next.prod   = 31'(in_pixel.pos_y[14:0]) * 31'(w_sel);
        s1_next.wh     = 30'(cfg.image_width) * 30'(cfg.image_height);
        s1_next.lum_r  = pfw_pkg::LUMA_R * 24'(in_pixel.red);
        s1_next.lum_g  = pfw_pkg::LUMA_G * 24'(in_pixel.green);
        s1_next.lum_b  = pfw_pkg::LUMA_B * 24'(in_pixel.blue);
        s1_next.bright = 1'b0;
        begin
            logic [7:0] level;
            level = {2'b00, in_pixel.red[7:2]} + {1'b0, in_pixel.green[7:1]}
                  + {2'b00, in_pixel.blue[7:2]};
            s1_next.bright = level[7];
        end
        s1_next.r = in_pixel.red;
        s1_next.g = in_pixel.green;
        s1_next.b = in_pixel.blue;
        s1_next.a = in_pixel.alpha;
    end

    always_comb
    begin
        lum_sum      = s1_reg.lum_r + s1_reg.lum_g + s1_reg.lum_b;
        s2_next.oor  = s1_reg.oor;
        s2_next.idx  = 31'(s1_reg.x) + s1_reg.prod;
        s2_next.wh   = s1_reg.wh;
        s2_next.a    = s1_reg.a;
        s2_next.gray = lum_sum[23:16];
        s2_next.on   = s1_reg.bright;
        s2_next.r    = s1_reg.r;
        s2_next.g    = s1_reg.g;
        s2_next.b    = s1_reg.b;
        if ((chroma || alpha_ch) && (s1_reg.a < pfw_pkg::HALF_ALPHA))
        begin
            s2_next.on = 1'b0;
        end
        if (chroma)
        begin
            if (lum_sum[23:16] == 8'd1)
            begin
                s2_next.gray = 8'd0;
            end
            if (s1_reg.a < pfw_pkg::HALF_ALPHA)
            begin
                s2_next.gray = 8'd1;
            end
            if ((s1_reg.g == 8'd1) && (s1_reg.r == 8'd0) && (s1_reg.b == 8'd0))
            begin
                s2_next.g = 8'd0;
            end
            if (s1_reg.a < pfw_pkg::HALF_ALPHA)
            begin
                s2_next.r = 8'd0;
                s2_next.b = 8'd0;
                s2_next.g = (cfg.pixel_format == pfw_pkg::FMT_RGB565) ? 8'd4 : 8'd1;
            end
        end
        else if (alpha_ch)
        begin
            if (s1_reg.a != pfw_pkg::FULL_BYTE)
            begin
                s2_next.gray = s1_reg.a;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_reg <= s1_next;
        end
        if (en2)
        begin
            s2_reg <= s2_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_calc  = s2_reg;

endmodule

### rtl/pfw_layout.sv
// third pipeline stage: byte addresses, data and beat count for one pixel
module pfw_layout (
    input  logic              clk,
    input  logic              rst_n,
    input  pfw_pkg::cfg_t     cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  pfw_pkg::calc_t    in_calc,
    output logic              out_valid,
    input  logic              out_ready,
    output pfw_pkg::beat_set_t out_set
);

    pfw_pkg::beat_set_t set_next;
    pfw_pkg::beat_set_t set_reg;
    logic               v_reg;
    logic               en;
    logic               alpha_ch;
    logic [15:0]        rgb565;
    logic [31:0]        base;
    logic [7:0]         bit_sel;

    assign en       = !v_reg || out_ready;
    assign in_ready = en;
    assign alpha_ch = (cfg.transparency_mode == pfw_pkg::MODE_ALPHA);

    always_comb
    begin
        rgb565  = {in_calc.r[7:3], in_calc.g[7:2], in_calc.b[7:3]};
        bit_sel = 8'h80 >> in_calc.idx[2:0];
        base    = 32'd0;
        set_next.last_idx = 2'd0;
        set_next.oor      = 1'b0;
        set_next.mask     = pfw_pkg::FULL_BYTE;
        set_next.addr     = '0;
        set_next.data     = '0;
        if (in_calc.oor)
        begin
            set_next.oor  = 1'b1;
            set_next.mask = 8'h00;
        end
        else
        begin
            case (cfg.pixel_format)
                pfw_pkg::FMT_BINARY:
                begin
                    set_next.addr[0] = 32'(in_calc.idx[30:3]);
                    set_next.mask    = bit_sel;
                    set_next.data[0] = in_calc.on ? bit_sel : 8'h00;
                end
                pfw_pkg::FMT_GRAYSCALE:
                begin
                    set_next.addr[0] = 32'(in_calc.idx);
                    set_next.data[0] = in_calc.gray;
                end
                pfw_pkg::FMT_RGB565:
                begin
                    base             = {in_calc.idx, 1'b0};
                    set_next.addr[0] = base;
                    set_next.addr[1] = base + 32'd1;
                    set_next.addr[2] = 32'(in_calc.idx) + {1'b0, in_calc.wh, 1'b0};
                    set_next.data[0] = cfg.big_endian ? rgb565[15:8] : rgb565[7:0];
                    set_next.data[1] = cfg.big_endian ? rgb565[7:0] : rgb565[15:8];
                    set_next.data[2] = in_calc.a;
                    set_next.last_idx = alpha_ch ? 2'd2 : 2'd1;
                end
                default:
                begin
                    base = alpha_ch ? 32'({in_calc.idx, 2'b00})
                                    : 32'(in_calc.idx) + 32'({in_calc.idx, 1'b0});
                    set_next.addr[0] = base;
                    set_next.addr[1] = base + 32'd1;
                    set_next.addr[2] = base + 32'd2;
                    set_next.addr[3] = base + 32'd3;
                    set_next.data[0] = in_calc.b;
                    set_next.data[1] = in_calc.g;
                    set_next.data[2] = in_calc.r;
                    set_next.data[3] = in_calc.a;
                    set_next.last_idx = alpha_ch ? 2'd3 : 2'd2;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            set_reg <= set_next;
        end
    end

    assign out_valid = v_reg;
    assign out_set   = set_reg;

endmodule

### rtl/pfw_beat_gen.sv
// output stage: sends the byte writes of one pixel as beats, one per cycle while out_ready is high
module pfw_beat_gen (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  pfw_pkg::beat_set_t in_set,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [31:0]        out_addr,
    output logic [7:0]         out_data,
    output logic [7:0]         out_mask,
    output logic               out_oor,
    output logic               out_last
);

    logic [3:0][31:0] addr_reg;
    logic [3:0][7:0]  data_reg;
    logic [7:0]       mask_reg;
    logic             oor_reg;
    logic [1:0]       cnt_reg;
    logic [1:0]       cnt_next;
    logic             v_reg;
    logic             last;
    logic             load;
    logic             shift;

    assign last     = (cnt_reg == 2'd0);
    assign in_ready = !v_reg || (out_ready && last);
    assign load     = in_ready && in_valid;
    assign shift    = v_reg && out_ready && !last;
    assign cnt_next = cnt_reg - 2'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg   <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else if (in_ready)
        begin
            v_reg   <= in_valid;
            cnt_reg <= in_set.last_idx;
        end
        else if (shift)
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            addr_reg <= in_set.addr;
            data_reg <= in_set.data;
            mask_reg <= in_set.mask;
            oor_reg  <= in_set.oor;
        end
        else if (shift)
        begin
            addr_reg[0] <= addr_reg[1];
            addr_reg[1] <= addr_reg[2];
            addr_reg[2] <= addr_reg[3];
            data_reg[0] <= data_reg[1];
            data_reg[1] <= data_reg[2];
            data_reg[2] <= data_reg[3];
        end
    end

    assign out_valid = v_reg;
    assign out_addr  = addr_reg[0];
    assign out_data  = data_reg[0];
    assign out_mask  = mask_reg;
    assign out_oor   = oor_reg;
    assign out_last  = last;

endmodule

### rtl/framebuffer_pixel_writer_core.sv
// top level of the framebuffer pixel writer: configuration registers and pipeline
// Each input beat is one pixel; the block answers with the byte writes that store it in
// the configured format: one beat for binary, grayscale and pixels outside the image,
// two or three for RGB565, three or four for RGB888/RGBA8888. A pixel can enter every
// cycle unless back-pressure stalls it, and it passes four register stages (bounds and
// multiplies, index and color rules, addresses, output) ahead of its first beat.
// The output stage sends one byte write per cycle while m_axis_tready is high, and it
// takes the next pixel as the last write of the current one is accepted. The user must
// write configuration only while no pixel is in flight; the block itself does not enforce it.
module framebuffer_pixel_writer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [14:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // pos_x, pos_y, red, green, blue, alpha
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // byte_address, byte_data, bit_mask
    output logic        m_axis_tuser,  // out_of_range
    output logic        m_axis_tlast
);

    logic [1:0]  pixel_format_reg;
    logic [1:0]  transparency_mode_reg;
    logic        big_endian_reg;
    logic [14:0] image_width_reg;
    logic [14:0] image_height_reg;

    pfw_pkg::cfg_t      cfg;
    pfw_pkg::calc_t     calc;
    pfw_pkg::beat_set_t beat_set;
    logic               calc_valid;
    logic               calc_ready;
    logic               set_valid;
    logic               set_ready;
    logic [31:0]        out_addr;
    logic [7:0]         out_data;
    logic [7:0]         out_mask;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_format_reg      <= pfw_pkg::FMT_BINARY;
            transparency_mode_reg <= pfw_pkg::MODE_OPAQUE;
            big_endian_reg        <= 1'b0;
            image_width_reg       <= 15'd1;
            image_height_reg      <= 15'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pfw_pkg::REG_PIXEL_FORMAT:      pixel_format_reg      <= cfg_data[1:0];
                pfw_pkg::REG_TRANSPARENCY_MODE: transparency_mode_reg <= cfg_data[1:0];
                pfw_pkg::REG_BIG_ENDIAN:        big_endian_reg        <= cfg_data[0];
                pfw_pkg::REG_IMAGE_WIDTH:       image_width_reg       <= cfg_data;
                pfw_pkg::REG_IMAGE_HEIGHT:      image_height_reg      <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.pixel_format      = pixel_format_reg;
    assign cfg.transparency_mode = transparency_mode_reg;
    assign cfg.big_endian        = big_endian_reg;
    assign cfg.image_width       = image_width_reg;
    assign cfg.image_height      = image_height_reg;

    pfw_calc u_calc (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_pixel  (s_axis_tdata),
        .out_valid (calc_valid),
        .out_ready (calc_ready),
        .out_calc  (calc)
    );

    pfw_layout u_layout (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (calc_valid),
        .in_ready  (calc_ready),
        .in_calc   (calc),
        .out_valid (set_valid),
        .out_ready (set_ready),
        .out_set   (beat_set)
    );

    pfw_beat_gen u_beat_gen (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (set_valid),
        .in_ready  (set_ready),
        .in_set    (beat_set),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_addr  (out_addr),
        .out_data  (out_data),
        .out_mask  (out_mask),
        .out_oor   (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {out_mask, out_data, out_addr};

endmodule

### tb/sv/framebuffer_pixel_writer_core_test.sv
// self-checking testbench for framebuffer_pixel_writer_core: directed and random pixels against a predictor
module framebuffer_pixel_writer_core_test;

    import pfw_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASES       = 12;
    localparam int PHASE_PIXELS = 30;

    typedef struct {
        logic [31:0] addr;
        logic [7:0]  data;
        logic [7:0]  mask;
        logic        oor;
        logic        last;
    } byte_write_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [14:0] cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;  // pos_x, pos_y, red, green, blue, alpha
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;       // byte_address, byte_data, bit_mask
    logic        m_axis_tuser;       // out_of_range
    logic        m_axis_tlast;

    cfg_t          shadow;
    pixel_t        pixel_queue[$];
    byte_write_t   writes_due[$];
    byte_write_t   due;
    pixel_t        next_pixel;
    logic          next_valid;
    logic          rx_ready;
    logic          gapless = 1'b0;
    logic          rx_hold_request = 1'b0;
    logic          rx_hold_taken = 1'b0;
    int            send_gap = 0;
    int            recv_gap = 0;
    int            hold_left = 0;
    int            quiet_cycles = 0;
    int            pixels_pushed = 0;
    int            pixels_sent = 0;
    int            writes_seen = 0;
    int            oor_seen = 0;
    int            settings_count = 0;
    int            failures = 0;

    framebuffer_pixel_writer_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #4 clk = ~clk;

    function automatic byte_write_t byte_write(logic [63:0] addr, logic [7:0] data,
                                               logic [7:0] mask, logic oor);
        byte_write_t bw;
        bw.addr = addr[31:0];
        bw.data = data;
        bw.mask = mask;
        bw.oor  = oor;
        bw.last = 1'b0;
        return bw;
    endfunction

    function automatic void predict_writes(pixel_t px);
        logic [63:0] w;
        logic [63:0] h;
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] idx;
        logic [63:0] pos;
        logic [8:0]  brightness;
        logic [31:0] luma;
        logic [15:0] rgb565;
        logic [7:0]  gray;
        logic [7:0]  mr;
        logic [7:0]  mg;
        logic [7:0]  mb;
        logic [7:0]  bitsel;
        logic        lit;
        logic        keyed;
        logic        with_alpha;
        byte_write_t burst[$];
        w = 64'(shadow.image_width);
        h = 64'(shadow.image_height);
        x = 64'(px.pos_x);
        y = 64'(px.pos_y);
        keyed = (shadow.transparency_mode == MODE_CHROMA);
        with_alpha = (shadow.transparency_mode == MODE_ALPHA);
        if (px.pos_x[15] || px.pos_y[15] || w == 0 || h == 0 || w > 64'(MAX_DIM) ||
            h > 64'(MAX_DIM) || x >= w || y >= h)
        begin
            burst.push_back(byte_write(64'd0, 8'd0, 8'd0, 1'b1));
        end
        else
        begin
            idx = x + y * w;
            case (shadow.pixel_format)
                FMT_BINARY:
                begin
                    pos = x + y * (((w + 7) / 8) * 8);
                    bitsel = 8'h80 >> pos[2:0];
                    brightness = (px.red >> 2) + (px.green >> 1) + (px.blue >> 2);
                    lit = brightness[7] && !((keyed || with_alpha) && px.alpha < HALF_ALPHA);
                    burst.push_back(byte_write(pos >> 3, lit ? bitsel : 8'd0, bitsel, 1'b0));
                end
                FMT_GRAYSCALE:
                begin
                    luma = LUMA_R * px.red + LUMA_G * px.green + LUMA_B * px.blue;
                    gray = luma[23:16];
                    if (keyed)
                    begin
                        if (gray == 8'd1)
                            gray = 8'd0;
                        if (px.alpha < HALF_ALPHA)
                            gray = 8'd1;
                    end
                    else if (with_alpha && px.alpha != FULL_BYTE)
                    begin
                        gray = px.alpha;
                    end
                    burst.push_back(byte_write(idx, gray, FULL_BYTE, 1'b0));
                end
                default:
                begin
                    mr = px.red;
                    mg = px.green;
                    mb = px.blue;
                    if (keyed)
                    begin
                        // the key color itself is reserved for transparent pixels
                        if (mg == 8'd1 && mr == 8'd0 && mb == 8'd0)
                            mg = 8'd0;
                        if (px.alpha < HALF_ALPHA)
                        begin
                            mr = 8'd0;
                            mg = (shadow.pixel_format == FMT_RGB565) ? 8'd4 : 8'd1;
                            mb = 8'd0;
                        end
                    end
                    if (shadow.pixel_format == FMT_RGB565)
                    begin
                        rgb565 = {mr[7:3], mg[7:2], mb[7:3]};
                        pos = idx * 2;
                        burst.push_back(byte_write(pos, shadow.big_endian ? rgb565[15:8] :
                                                   rgb565[7:0], FULL_BYTE, 1'b0));
                        burst.push_back(byte_write(pos + 1, shadow.big_endian ? rgb565[7:0] :
                                                   rgb565[15:8], FULL_BYTE, 1'b0));
                        if (with_alpha)
                            burst.push_back(byte_write(idx + w * h * 2, px.alpha, FULL_BYTE,
                                                       1'b0));
                    end
                    else
                    begin
                        pos = idx * (with_alpha ? 64'd4 : 64'd3);
                        burst.push_back(byte_write(pos, mb, FULL_BYTE, 1'b0));
                        burst.push_back(byte_write(pos + 1, mg, FULL_BYTE, 1'b0));
                        burst.push_back(byte_write(pos + 2, mr, FULL_BYTE, 1'b0));
                        if (with_alpha)
                            burst.push_back(byte_write(pos + 3, px.alpha, FULL_BYTE, 1'b0));
                    end
                end
            endcase
        end
        burst[burst.size() - 1].last = 1'b1;
        foreach (burst[k])
            writes_due.push_back(burst[k]);
    endfunction

    function automatic void check_field(string name, logic [31:0] wanted, logic [31:0] seen);
        if (seen !== wanted)
        begin
            $error("%s: expected %0h, got %0h", name, wanted, seen);
            failures++;
        end
    endfunction

    function automatic logic [7:0] random_level();
        case ($urandom_range(0, 5))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [14:0] random_dim();
        case ($urandom_range(0, 4))
            0: return 15'd1;
            1: return MAX_DIM;
            2: return 15'($urandom_range(1, 16));
            default: return 15'($urandom_range(1, 32767));
        endcase
    endfunction

    function automatic pixel_t random_pixel();
        pixel_t px;
        int     w;
        int     h;
        w = shadow.image_width;
        h = shadow.image_height;
        px.pos_x = (w == 0) ? 16'($urandom_range(0, 40)) : 16'($urandom_range(0, w - 1));
        px.pos_y = (h == 0) ? 16'($urandom_range(0, 40)) : 16'($urandom_range(0, h - 1));
        case ($urandom_range(0, 11))
            0: px.pos_x = 16'($urandom_range(32768, 65535));
            1: px.pos_y = 16'($urandom_range(32768, 65535));
            2: px.pos_x = 16'($urandom_range(w, 32767));
            3: px.pos_y = 16'($urandom_range(h, 32767));
            default: ;
        endcase
        px.red   = random_level();
        px.green = random_level();
        px.blue  = random_level();
        case ($urandom_range(0, 5))
            0: px.alpha = 8'd0;
            1: px.alpha = 8'd127;
            2: px.alpha = 8'd128;
            3: px.alpha = 8'd255;
            default: px.alpha = 8'($urandom_range(0, 255));
        endcase
        // near-key colors
        if ($urandom_range(0, 9) == 0)
        begin
            px.red   = 8'd0;
            px.green = 8'($urandom_range(1, 2));
            px.blue  = 8'd0;
        end
        return px;
    endfunction

    task automatic queue_pixel(int x, int y, int r, int g, int b, int a);
        pixel_t px;
        px.pos_x = 16'(x);
        px.pos_y = 16'(y);
        px.red   = 8'(r);
        px.green = 8'(g);
        px.blue  = 8'(b);
        px.alpha = 8'(a);
        pixel_queue.push_back(px);
        pixels_pushed++;
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (pixels_sent != pixels_pushed || writes_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] index, logic [14:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        case (index)
            REG_PIXEL_FORMAT:      shadow.pixel_format      = value[1:0];
            REG_TRANSPARENCY_MODE: shadow.transparency_mode = value[1:0];
            REG_BIG_ENDIAN:        shadow.big_endian        = value[0];
            REG_IMAGE_WIDTH:       shadow.image_width       = value;
            REG_IMAGE_HEIGHT:      shadow.image_height      = value;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic apply_settings(logic [1:0] fmt, logic [1:0] mode, logic be,
                                  logic [14:0] w, logic [14:0] h);
        wait_drained();
        write_reg(REG_PIXEL_FORMAT, 15'(fmt));
        write_reg(REG_TRANSPARENCY_MODE, 15'(mode));
        write_reg(REG_BIG_ENDIAN, 15'(be));
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        cfg_we <= 1'b0;
        settings_count++;
    endtask

    // pixel beats
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            send_gap = 0;
        end
        else
        begin
            next_valid = s_axis_tvalid;
            next_pixel = s_axis_tdata;
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_writes(s_axis_tdata);
                pixels_sent++;
                next_valid = 1'b0;
            end
            if (!next_valid)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (pixel_queue.size() > 0)
                begin
                    if (!gapless && $urandom_range(0, 7) == 0)
                        send_gap = $urandom_range(1, 10) - 1;
                    else
                    begin
                        next_pixel = pixel_queue.pop_front();
                        next_valid = 1'b1;
                    end
                end
            end
            s_axis_tvalid <= next_valid;
            s_axis_tdata  <= next_pixel;
        end
    end

    // byte write beats
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            recv_gap = 0;
            hold_left = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                writes_seen++;
                if (m_axis_tuser)
                    oor_seen++;
                if (writes_due.size() == 0)
                begin
                    $error("byte write with none expected: address %0h", m_axis_tdata[31:0]);
                    failures++;
                end
                else
                begin
                    due = writes_due.pop_front();
                    check_field("byte_address", due.addr, m_axis_tdata[31:0]);
                    check_field("byte_data", 32'(due.data), 32'(m_axis_tdata[39:32]));
                    check_field("bit_mask", 32'(due.mask), 32'(m_axis_tdata[47:40]));
                    check_field("out_of_range", 32'(due.oor), 32'(m_axis_tuser));
                    check_field("last_write", 32'(due.last), 32'(m_axis_tlast));
                end
            end
            if (rx_hold_request && !rx_hold_taken)
            begin
                rx_hold_taken = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rx_ready = 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                rx_ready = 1'b0;
            end
            else if (!gapless && $urandom_range(0, 7) == 0)
            begin
                recv_gap = $urandom_range(1, 10) - 1;
                rx_ready = 1'b0;
            end
            else
                rx_ready = 1'b1;
            m_axis_tready <= rx_ready;
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int phase;
        int n;
        shadow.pixel_format      = FMT_BINARY;
        shadow.transparency_mode = MODE_OPAQUE;
        shadow.big_endian        = 1'b0;
        shadow.image_width       = 15'd1;
        shadow.image_height      = 15'd1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: a 1x1 binary image
        queue_pixel(0, 0, 255, 255, 255, 255);
        queue_pixel(0, 0, 0, 0, 0, 0);
        queue_pixel(1, 0, 255, 255, 255, 255);
        queue_pixel(0, 1, 255, 255, 255, 255);
        queue_pixel(-1, 0, 255, 255, 255, 255);
        queue_pixel(0, -32768, 255, 255, 255, 255);
        queue_pixel(32767, 32767, 255, 255, 255, 255);

        // binary with padded rows, low alpha forces the bit off
        apply_settings(FMT_BINARY, MODE_ALPHA, 1'b0, 15'd9, 15'd3);
        queue_pixel(8, 2, 255, 255, 255, 127);
        queue_pixel(7, 1, 255, 255, 255, 128);

        apply_settings(FMT_GRAYSCALE, MODE_CHROMA, 1'b0, 15'd4, 15'd4);
        queue_pixel(3, 3, 0, 2, 0, 255);
        queue_pixel(0, 0, 255, 255, 255, 0);
        queue_pixel(1, 1, 255, 255, 255, 255);

        // undefined transparency mode behaves as opaque
        apply_settings(FMT_GRAYSCALE, 2'd3, 1'b0, 15'd4, 15'd4);
        queue_pixel(2, 2, 10, 20, 30, 0);

        apply_settings(FMT_RGB565, MODE_ALPHA, 1'b1, MAX_DIM, MAX_DIM);
        queue_pixel(32766, 32766, 255, 0, 255, 200);
        queue_pixel(0, 0, 18, 52, 86, 255);

        apply_settings(FMT_RGB565, MODE_CHROMA, 1'b0, 15'd5, 15'd5);
        queue_pixel(4, 4, 0, 1, 0, 255);
        queue_pixel(1, 2, 77, 88, 99, 10);

        apply_settings(FMT_RGB888, MODE_ALPHA, 1'b0, MAX_DIM, MAX_DIM);
        queue_pixel(32766, 32766, 1, 2, 3, 4);

        apply_settings(FMT_RGB888, MODE_CHROMA, 1'b0, 15'd3, 15'd2);
        queue_pixel(0, 0, 0, 1, 0, 128);
        queue_pixel(1, 0, 9, 9, 9, 127);

        // zero width or height: no framebuffer at all
        apply_settings(FMT_RGB888, MODE_OPAQUE, 1'b0, 15'd0, 15'd5);
        queue_pixel(0, 0, 1, 2, 3, 4);
        apply_settings(FMT_RGB565, MODE_OPAQUE, 1'b0, 15'd5, 15'd0);
        queue_pixel(0, 0, 1, 2, 3, 4);

        for (phase = 0; phase < PHASES; phase++)
        begin
            if (phase == 2)
                apply_settings(FMT_RGB888, MODE_ALPHA, 1'($urandom_range(0, 1)),
                               random_dim(), random_dim());
            else
                apply_settings(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                               1'($urandom_range(0, 1)), random_dim(), random_dim());
            if (phase == PHASES - 1)
                gapless = 1'b1;
            for (n = 0; n < PHASE_PIXELS; n++)
            begin
                pixel_queue.push_back(random_pixel());
                pixels_pushed++;
            end
            // stall the output long enough to back the pipeline up into the input
            if (phase == 2)
                rx_hold_request = 1'b1;
        end

        wait_drained();
        $display("covered %0d pixels over %0d register settings", pixels_sent, settings_count);
        $display("checked %0d byte writes, %0d of them out of range", writes_seen, oor_seen);
        if (failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
